FILE: rtl/core/rar_pkg.sv
// Package for the rational arithmetic reducer: payload types and opcodes.
package rar_pkg;

  localparam int unsigned WordWidth = 32;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0]                  req_type;
    logic signed [WordWidth-1:0] a_num;
    logic signed [WordWidth-1:0] a_den;
    logic signed [WordWidth-1:0] b_num;
    logic signed [WordWidth-1:0] b_den;
  } in_word_t;

  typedef struct packed {
    logic signed [WordWidth-1:0] res_num;
    logic signed [WordWidth-1:0] res_den;
    logic                        error;
  } out_word_t;

endpackage

FILE: rtl/core/rational_arithmetic_reduce.sv
// Rational add/sub/mul/div with Euclid gcd reduction on one shared serial divider.
//
//  channel | ports                     | dir | payload
//  in      | in_valid/in_ready/in_data  | in  | in_word_t (op, two fractions)
//  out     | out_valid/out_ready/out_data| out | out_word_t (num, den, error)
//
// Products: one 32x32 multiply per cycle on one multiplier, in states M0, M1 and M2.
// Each gcd remainder step runs check, a WordWidth-bit restoring divide on the
// shared divider, done wait and update; each final quotient runs a divider
// start and a done wait. An item passes the products, the gcd steps and the
// two quotients before the next accept; a zero gcd skips the quotients, flags
// an error and goes to the result. Not ready while busy or while the result
// waits. Synchronous active-low reset returns to idle.
module rational_arithmetic_reduce
  import rar_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  localparam int unsigned W  = WordWidth;
  localparam int unsigned CW = $clog2(W + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_M0, S_M1, S_M2, S_M3, S_GCHK, S_GDIV, S_GUPD,
    S_QN, S_QNW, S_QD, S_QDW, S_OUT
  } state_t;

  state_t       state_r;
  op_t          op_r;
  logic [W-1:0] an_r, ad_r, bn_r, bd_r;
  logic [W-1:0] p_r, num_r, den_r, ga_r, gb_r;
  logic         err_r;
  // divider: magnitudes, quotient/remainder shift registers
  logic [W-1:0] dvd_r, dvs_r, quo_r;
  logic [W:0]   rem_r;
  logic [CW-1:0] cnt_r;
  logic         dbusy_r;
  logic         neg_r;
  logic         start;
  logic [W-1:0] s_a, s_b;

  // shared multiplier operands
  logic [W-1:0] m_x, m_y, m_p;
  always_comb begin
    unique case (state_r)
      S_M0:    begin m_x = an_r; m_y = (op_r == OP_MUL) ? bn_r : bd_r; end
      S_M1:    begin m_x = bn_r; m_y = ad_r; end
      default: begin m_x = ad_r; m_y = (op_r == OP_DIV) ? bn_r : bd_r; end
    endcase
  end
  assign m_p = W'(m_x * m_y);

  function automatic logic [W-1:0] mag(input logic [W-1:0] v);
    return v[W-1] ? W'(-v) : v;
  endfunction

  // one restoring step of the shared divider
  logic [W:0] trial;
  assign trial = {rem_r[W-1:0], dvd_r[W-1]} - {1'b0, dvs_r};

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_data  = '{res_num: num_r, res_den: den_r, error: err_r};

  always_comb begin
    start = 1'b0;
    s_a   = ga_r;
    s_b   = gb_r;
    unique case (state_r)
      S_GCHK:  begin start = (gb_r != '0); end
      S_QN:    begin start = 1'b1; s_a = num_r; s_b = ga_r; end
      S_QD:    begin start = 1'b1; s_a = den_r; s_b = ga_r; end
      default: ;
    endcase
  end

  logic [W-1:0] rem_s, quo_s;
  assign rem_s = neg_r ? W'(-rem_r[W-1:0]) : rem_r[W-1:0];
  assign quo_s = neg_r ? W'(-quo_r) : quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      dbusy_r <= 1'b0;
    end else begin
      // divider sequencing
      if (start) begin
        dvd_r   <= mag(s_a);
        dvs_r   <= mag(s_b);
        rem_r   <= '0;
        quo_r   <= '0;
        cnt_r   <= CW'(W);
        dbusy_r <= 1'b1;
        neg_r   <= (state_r == S_GCHK) ? s_a[W-1] : (s_a[W-1] ^ s_b[W-1]);
      end else if (dbusy_r) begin
        dvd_r <= {dvd_r[W-2:0], 1'b0};
        if (!trial[W]) begin
          rem_r <= {1'b0, trial[W-1:0]};
          quo_r <= {quo_r[W-2:0], 1'b1};
        end else begin
          rem_r <= {rem_r[W-1:0], dvd_r[W-1]};
          quo_r <= {quo_r[W-2:0], 1'b0};
        end
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) dbusy_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: if (in_valid) begin
          op_r  <= op_t'(in_data.req_type);
          an_r  <= in_data.a_num;
          ad_r  <= in_data.a_den;
          bn_r  <= in_data.b_num;
          bd_r  <= in_data.b_den;
          err_r <= 1'b0;
          state_r <= S_M0;
        end
        S_M0: begin num_r <= m_p; state_r <= S_M1; end
        S_M1: begin p_r <= m_p; state_r <= S_M2; end
        S_M2: begin
          den_r <= m_p;
          ga_r  <= (op_r == OP_ADD) ? num_r + p_r :
                   (op_r == OP_SUB) ? num_r - p_r : num_r;
          gb_r  <= m_p;
          state_r <= S_M3;
        end
        S_M3: begin num_r <= ga_r; state_r <= S_GCHK; end
        S_GCHK: begin
          if (gb_r != '0) state_r <= S_GDIV;
          else if (ga_r == '0) begin err_r <= 1'b1; state_r <= S_OUT; end
          else state_r <= S_QN;
        end
        S_GDIV: if (!dbusy_r) state_r <= S_GUPD;
        S_GUPD: begin ga_r <= gb_r; gb_r <= rem_s; state_r <= S_GCHK; end
        S_QN:   state_r <= S_QNW;
        S_QNW: if (!dbusy_r) begin
          num_r <= quo_s;
          if (!neg_r && quo_r[W-1]) err_r <= 1'b1;
          state_r <= S_QD;
        end
        S_QD:   state_r <= S_QDW;
        S_QDW: if (!dbusy_r) begin
          den_r <= quo_s;
          if (!neg_r && quo_r[W-1]) err_r <= 1'b1;
          state_r <= S_OUT;
        end
        S_OUT: if (out_ready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // checks
  a_div_only_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !dbusy_r) else $error("divider restarted while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("ready while result pending");

endmodule
